// ----- design/mmcd_pkg.sv -----
// Shared constants and types for the min/max column decimator.
`timescale 1ns / 1ps
`default_nettype none
package mmcd_pkg;

  // Configuration register indexes
  localparam int           CFG_IDX_BITS  = 2;
  localparam int           CFG_DATA_BITS = 32;
  localparam logic [1:0]   CFG_VIEW_MIN  = 2'd0;
  localparam logic [1:0]   CFG_SCALE     = 2'd1;
  localparam logic [1:0]   CFG_COLUMNS   = 2'd2;

  localparam int           POS_BITS      = 32;
  localparam int           INT_BITS      = 32;
  localparam int           COLS_BITS     = 13;

  localparam logic [31:0]  RESET_VIEW_MIN = 32'd0;
  localparam logic [31:0]  RESET_SCALE    = 32'd65536;
  localparam logic [12:0]  RESET_COLUMNS  = 13'd1024;
  localparam logic [31:0]  PEAK_FLOOR     = 32'd1;

  // Candidate result slots per transaction: closed run, then final run
  localparam int           SLOTS       = 8;
  localparam int           GROUP       = 4;
  localparam int           QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [SLOTS-1:0] emit;
    logic             scan_last;
  } mmcd_ctl_t;

endpackage
`default_nettype wire

// ----- design/mmcd_column.sv -----
// Front pipeline: maps a point position to its clamped display column.
`timescale 1ns / 1ps
`default_nettype none
module mmcd_column
  import mmcd_pkg::*;
#(
  parameter int INDEX_BITS  = 24,
  parameter int MAX_COLUMNS = 4096,
  parameter int COL_BITS    = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [POS_BITS-1:0]   position_i,
  input  wire logic [INT_BITS-1:0]   intensity_i,
  input  wire logic [INDEX_BITS-1:0] index_i,
  input  wire logic                  last_i,
  input  wire logic [31:0]           view_min_i,
  input  wire logic [31:0]           scale_i,
  input  wire logic [COLS_BITS-1:0]  columns_i,
  output logic                       valid_o,
  output logic [COL_BITS-1:0]        col_o,
  output logic [INT_BITS-1:0]        intensity_o,
  output logic [INDEX_BITS-1:0]      index_o,
  output logic                       last_o
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);

  // stage 1: signed distance from the view edge, as sign and magnitude
  logic                  s1_valid_r;
  logic                  s1_neg_r;
  logic [31:0]           s1_mag_r;
  logic [INT_BITS-1:0]   s1_int_r;
  logic [INDEX_BITS-1:0] s1_idx_r;
  logic                  s1_last_r;
  // stage 2: Q48.16 product
  logic                  s2_valid_r;
  logic                  s2_neg_r;
  logic [63:0]           s2_prod_r;
  logic [INT_BITS-1:0]   s2_int_r;
  logic [INDEX_BITS-1:0] s2_idx_r;
  logic                  s2_last_r;
  // stage 3: clamped column
  logic                  s3_valid_r;
  logic [COL_BITS-1:0]   s3_col_r;
  logic [INT_BITS-1:0]   s3_int_r;
  logic [INDEX_BITS-1:0] s3_idx_r;
  logic                  s3_last_r;

  logic [32:0]         diff;
  logic [31:0]         mag_nxt;
  logic [63:0]         prod_nxt;
  logic [48:0]         quot;
  logic [CW-1:0]       c_eff;
  logic [CW:0]         limit;
  logic [CW:0]         quot_clamped;
  logic [COL_BITS-1:0] col_mag;
  logic [COL_BITS-1:0] col_nxt;

  assign diff     = {1'b0, position_i} - {1'b0, view_min_i};
  assign mag_nxt  = diff[32] ? (32'd0 - diff[31:0]) : diff[31:0];
  assign prod_nxt = {32'd0, s1_mag_r} * {32'd0, scale_i};

  always_comb begin
    if (columns_i == '0) begin
      c_eff = CW'(1);
    end else if (32'(columns_i) > 32'(MAX_COLUMNS)) begin
      c_eff = CW'(MAX_COLUMNS);
    end else begin
      c_eff = CW'(columns_i);
    end
  end

  // left of the view the floor rounds away from zero: add one if any fraction
  assign quot  = {1'b0, s2_prod_r[63:16]} + 49'(s2_neg_r && (s2_prod_r[15:0] != '0));
  assign limit = s2_neg_r ? {1'b0, c_eff} : {c_eff, 1'b0};

  always_comb begin
    if (quot > 49'(limit)) begin
      quot_clamped = limit;
    end else begin
      quot_clamped = quot[CW:0];
    end
    col_mag = COL_BITS'(quot_clamped);
    col_nxt = s2_neg_r ? (COL_BITS'(0) - col_mag) : col_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en_i) begin
      s1_valid_r <= valid_i;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      s1_neg_r  <= diff[32];
      s1_mag_r  <= mag_nxt;
      s1_int_r  <= intensity_i;
      s1_idx_r  <= index_i;
      s1_last_r <= last_i;

      s2_neg_r  <= s1_neg_r;
      s2_prod_r <= prod_nxt;
      s2_int_r  <= s1_int_r;
      s2_idx_r  <= s1_idx_r;
      s2_last_r <= s1_last_r;

      s3_col_r  <= col_nxt;
      s3_int_r  <= s2_int_r;
      s3_idx_r  <= s2_idx_r;
      s3_last_r <= s2_last_r;
    end
  end

  assign valid_o     = s3_valid_r;
  assign col_o       = s3_col_r;
  assign intensity_o = s3_int_r;
  assign index_o     = s3_idx_r;
  assign last_o      = s3_last_r;

endmodule
`default_nettype wire

// ----- design/mmcd_tracker.sv -----
// Front classifier: tracks the column run, sorts the flushed indices and removes repeats.
`timescale 1ns / 1ps
`default_nettype none
module mmcd_tracker
  import mmcd_pkg::*;
#(
  parameter int INDEX_BITS = 24,
  parameter int COL_BITS   = 15
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic [COL_BITS-1:0]                col_i,
  input  wire logic [INT_BITS-1:0]                intensity_i,
  input  wire logic [INDEX_BITS-1:0]              index_i,
  input  wire logic                               last_i,
  output logic                                    push_o,
  output mmcd_ctl_t                               ctl_o,
  output logic [SLOTS-1:0][INDEX_BITS-1:0]        idx_o,
  output logic [INT_BITS-1:0]                     peak_o
);

  typedef logic [GROUP-1:0][INDEX_BITS-1:0] grp_t;

  function automatic grp_t sort4(input grp_t v);
    grp_t                  s;
    logic [INDEX_BITS-1:0] t;
    s = v;
    if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
    if (s[2] > s[3]) begin t = s[2]; s[2] = s[3]; s[3] = t; end
    if (s[0] > s[2]) begin t = s[0]; s[0] = s[2]; s[2] = t; end
    if (s[1] > s[3]) begin t = s[1]; s[1] = s[3]; s[3] = t; end
    if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
    return s;
  endfunction

  // run state
  logic                  run_started_r;
  logic [COL_BITS-1:0]   cur_col_r;
  logic [INDEX_BITS-1:0] first_r;
  logic [INDEX_BITS-1:0] low_idx_r;
  logic [INT_BITS-1:0]   low_val_r;
  logic [INDEX_BITS-1:0] high_idx_r;
  logic [INT_BITS-1:0]   high_val_r;
  logic [INDEX_BITS-1:0] prev_r;
  logic [INT_BITS-1:0]   peak_r;
  // repeat filter state
  logic                  em_any_r;
  logic [INDEX_BITS-1:0] last_em_r;

  // stage 4: raw groups
  logic                  s4_valid_r;
  logic                  s4_g1v_r;
  grp_t                  s4_g1_r;
  grp_t                  s4_g2_r;
  logic                  s4_last_r;
  logic [INT_BITS-1:0]   s4_peak_r;
  // stage 5: sorted groups
  logic                  s5_valid_r;
  logic                  s5_g1v_r;
  grp_t                  s5_v1_r;
  grp_t                  s5_v2_r;
  logic                  s5_last_r;
  logic [INT_BITS-1:0]   s5_peak_r;

  logic                  col_change;
  logic                  new_run;
  logic [INDEX_BITS-1:0] first_nxt;
  logic [INDEX_BITS-1:0] low_idx_nxt;
  logic [INT_BITS-1:0]   low_val_nxt;
  logic [INDEX_BITS-1:0] high_idx_nxt;
  logic [INT_BITS-1:0]   high_val_nxt;
  logic [INT_BITS-1:0]   peak_nxt;
  logic                  any1;
  logic [INDEX_BITS-1:0] last1;
  logic [SLOTS-1:0]      emit;

  assign col_change = (col_i != cur_col_r);
  assign new_run    = !run_started_r || col_change;
  assign peak_nxt   = (intensity_i > peak_r) ? intensity_i : peak_r;

  always_comb begin
    if (new_run) begin
      first_nxt    = index_i;
      low_idx_nxt  = index_i;
      low_val_nxt  = intensity_i;
      high_idx_nxt = index_i;
      high_val_nxt = intensity_i;
    end else begin
      first_nxt    = first_r;
      low_idx_nxt  = low_idx_r;
      low_val_nxt  = low_val_r;
      high_idx_nxt = high_idx_r;
      high_val_nxt = high_val_r;
      if (intensity_i < low_val_r) begin
        low_idx_nxt = index_i;
        low_val_nxt = intensity_i;
      end
      if (intensity_i > high_val_r) begin
        high_idx_nxt = index_i;
        high_val_nxt = intensity_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_started_r <= 1'b0;
      cur_col_r     <= '0;
      peak_r        <= PEAK_FLOOR;
      s4_valid_r    <= 1'b0;
      s5_valid_r    <= 1'b0;
    end else if (en_i) begin
      s4_valid_r <= valid_i;
      s5_valid_r <= s4_valid_r;
      if (valid_i) begin
        // close the scan after its last point
        if (last_i) begin
          run_started_r <= 1'b0;
          cur_col_r     <= '0;
          peak_r        <= PEAK_FLOOR;
        end else begin
          run_started_r <= 1'b1;
          cur_col_r     <= col_i;
          peak_r        <= peak_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      if (valid_i) begin
        first_r    <= first_nxt;
        low_idx_r  <= low_idx_nxt;
        low_val_r  <= low_val_nxt;
        high_idx_r <= high_idx_nxt;
        high_val_r <= high_val_nxt;
        prev_r     <= index_i;
      end
      s4_g1v_r  <= run_started_r && col_change;
      s4_g1_r   <= {prev_r, high_idx_r, low_idx_r, first_r};
      s4_g2_r   <= {index_i, high_idx_nxt, low_idx_nxt, first_nxt};
      s4_last_r <= last_i;
      s4_peak_r <= peak_nxt;

      s5_g1v_r  <= s4_g1v_r;
      s5_v1_r   <= sort4(s4_g1_r);
      s5_v2_r   <= sort4(s4_g2_r);
      s5_last_r <= s4_last_r;
      s5_peak_r <= s4_peak_r;
    end
  end

  // Sorted groups hold repeats next to each other; only a group's head
  // looks back at what went out before it.
  always_comb begin
    emit    = '0;
    emit[0] = s5_g1v_r && (!em_any_r || (last_em_r != s5_v1_r[0]));
    for (int k = 1; k < GROUP; k++) begin
      emit[k] = s5_g1v_r && (s5_v1_r[k] != s5_v1_r[k-1]);
    end
    any1  = em_any_r || s5_g1v_r;
    last1 = s5_g1v_r ? s5_v1_r[GROUP-1] : last_em_r;
    emit[GROUP] = s5_last_r && (!any1 || (last1 != s5_v2_r[0]));
    for (int k = 1; k < GROUP; k++) begin
      emit[GROUP+k] = s5_last_r && (s5_v2_r[k] != s5_v2_r[k-1]);
    end
    // a scan end always gives at least one result: repeat the last index sent
    if (s5_last_r && (emit == '0)) begin
      emit[GROUP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_any_r  <= 1'b0;
      last_em_r <= '0;
    end else if (en_i && s5_valid_r) begin
      if (s5_last_r) begin
        em_any_r  <= 1'b0;
        last_em_r <= '0;
      end else if (s5_g1v_r) begin
        em_any_r  <= 1'b1;
        last_em_r <= s5_v1_r[GROUP-1];
      end
    end
  end

  assign push_o          = en_i && s5_valid_r && (emit != '0);
  assign ctl_o.emit      = emit;
  assign ctl_o.scan_last = s5_last_r;
  assign idx_o           = {s5_v2_r, s5_v1_r};
  assign peak_o          = s5_peak_r;

endmodule
`default_nettype wire

// ----- design/mmcd_queue.sv -----
// Short transaction queue between the classifier and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module mmcd_queue
  import mmcd_pkg::*;
#(
  parameter int WIDTH = 233
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    entry_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_BITS'(1);
  endfunction

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop_i) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_i) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop_i) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= data_i;
    end
  end

  assign full_o  = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_r != '0);
  assign data_o  = entry_r[rd_ptr_r];

endmodule
`default_nettype wire

// ----- design/mmcd_emitter.sv -----
// Back end: steps through the kept indices of each transaction into the output register.
`timescale 1ns / 1ps
`default_nettype none
module mmcd_emitter
  import mmcd_pkg::*;
#(
  parameter int INDEX_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid_i,
  input  wire mmcd_ctl_t                        q_ctl_i,
  input  wire logic [SLOTS-1:0][INDEX_BITS-1:0] q_idx_i,
  input  wire logic [INT_BITS-1:0]              q_peak_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [INDEX_BITS-1:0]                 out_index_o,
  output logic                                  out_run_end_o,
  output logic                                  out_scan_end_o,
  output logic [INT_BITS-1:0]                   out_peak_o
);

  logic                             job_valid_r;
  logic [SLOTS-1:0]                 rem_r;
  logic                             scan_last_r;
  logic [SLOTS-1:0][INDEX_BITS-1:0] idx_r;
  logic [INT_BITS-1:0]              peak_r;

  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] out_index_r;
  logic                  out_run_end_r;
  logic                  out_scan_end_r;
  logic [INT_BITS-1:0]   out_peak_r;

  logic                  out_load;
  logic [SLOTS-1:0]      sel_oh;
  logic [SLOTS-1:0]      rem_clr;
  logic [INDEX_BITS-1:0] sel_idx;
  logic                  job_last;
  logic                  emit_now;
  logic                  job_done;

  assign out_load = !out_valid_r || !out_stall_i;
  assign sel_oh   = rem_r & (~rem_r + SLOTS'(1));
  assign rem_clr  = rem_r & ~sel_oh;
  assign job_last = (rem_clr == '0);
  assign emit_now = out_load && job_valid_r;
  assign job_done = emit_now && job_last;
  assign pop_o    = q_valid_i && (!job_valid_r || job_done);

  always_comb begin
    sel_idx = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (sel_oh[k]) begin
        sel_idx = idx_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_o) begin
        job_valid_r <= 1'b1;
      end else if (job_done) begin
        job_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= job_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      rem_r       <= q_ctl_i.emit;
      scan_last_r <= q_ctl_i.scan_last;
      idx_r       <= q_idx_i;
      peak_r      <= q_peak_i;
    end else if (emit_now) begin
      rem_r <= rem_clr;
    end
    if (emit_now) begin
      out_index_r    <= sel_idx;
      out_run_end_r  <= job_last;
      out_scan_end_r <= job_last && scan_last_r;
      out_peak_r     <= peak_r;
    end
  end

  assign out_valid_o    = out_valid_r;
  assign out_index_o    = out_index_r;
  assign out_run_end_o  = out_run_end_r;
  assign out_scan_end_o = out_scan_end_r;
  assign out_peak_o     = out_peak_r;

endmodule
`default_nettype wire

// ----- design/minmax_column_decimator_unit.sv -----
// Top level of the min/max column decimator.
`timescale 1ns / 1ps
`default_nettype none
// Takes x-sorted points, one per cycle, maps each to a display column with
// a Q16.16 scale and, whenever the column changes and at the point marked
// last, sends out the first, minimum, maximum and previous point indices of
// the closed run in ascending order with repeats removed, together with the
// running peak intensity. A point enters in every cycle while the transaction
// queue has room; a point that yields n results sends them out one result
// per cycle while the receiver does not stall, and the four-entry queue
// between the classifier and the result sequencer absorbs bursts of up to
// five results. The front pipeline registers the difference, 32x32 multiply,
// clamp, run tracking and sort in turn. Configuration must be written only
// while no point is in flight; the block itself does not enforce this.
module minmax_column_decimator_unit
  import mmcd_pkg::*;
#(
  parameter int INDEX_BITS  = 24,
  parameter int MAX_COLUMNS = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [POS_BITS-1:0]      in_point_position,
  input  wire logic [INT_BITS-1:0]      in_point_intensity,
  input  wire logic [INDEX_BITS-1:0]    in_point_index,
  input  wire logic                     in_last_point,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [INDEX_BITS-1:0]         out_selected_index,
  output logic                          out_run_end,
  output logic                          out_scan_end,
  output logic [INT_BITS-1:0]           out_peak_intensity,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int COL_BITS = $clog2(MAX_COLUMNS + 1) + 2;
  localparam int Q_WIDTH  = $bits(mmcd_ctl_t) + SLOTS * INDEX_BITS + INT_BITS;

  logic [31:0]          view_min_r;
  logic [31:0]          scale_r;
  logic [COLS_BITS-1:0] columns_r;

  logic                             en;
  logic                             q_full;
  logic                             col_valid;
  logic [COL_BITS-1:0]              col;
  logic [INT_BITS-1:0]              col_int;
  logic [INDEX_BITS-1:0]            col_idx;
  logic                             col_last;
  logic                             push;
  mmcd_ctl_t                        push_ctl;
  logic [SLOTS-1:0][INDEX_BITS-1:0] push_idx;
  logic [INT_BITS-1:0]              push_peak;
  logic                             pop;
  logic                             q_valid;
  logic [Q_WIDTH-1:0]               q_data;
  mmcd_ctl_t                        q_ctl;
  logic [SLOTS-1:0][INDEX_BITS-1:0] q_idx;
  logic [INT_BITS-1:0]              q_peak;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_min_r <= RESET_VIEW_MIN;
      scale_r    <= RESET_SCALE;
      columns_r  <= RESET_COLUMNS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIEW_MIN: view_min_r <= cfg_data;
        CFG_SCALE:    scale_r    <= cfg_data;
        CFG_COLUMNS:  columns_r  <= cfg_data[COLS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // the whole front advances together; hold it while the queue is full
  assign en       = !q_full;
  assign in_stall = q_full;

  mmcd_column #(
    .INDEX_BITS  (INDEX_BITS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .COL_BITS    (COL_BITS)
  ) u_column (
    .clk         (clk),
    .rst_n       (rst_n),
    .en_i        (en),
    .valid_i     (in_valid),
    .position_i  (in_point_position),
    .intensity_i (in_point_intensity),
    .index_i     (in_point_index),
    .last_i      (in_last_point),
    .view_min_i  (view_min_r),
    .scale_i     (scale_r),
    .columns_i   (columns_r),
    .valid_o     (col_valid),
    .col_o       (col),
    .intensity_o (col_int),
    .index_o     (col_idx),
    .last_o      (col_last)
  );

  mmcd_tracker #(
    .INDEX_BITS (INDEX_BITS),
    .COL_BITS   (COL_BITS)
  ) u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .en_i        (en),
    .valid_i     (col_valid),
    .col_i       (col),
    .intensity_i (col_int),
    .index_i     (col_idx),
    .last_i      (col_last),
    .push_o      (push),
    .ctl_o       (push_ctl),
    .idx_o       (push_idx),
    .peak_o      (push_peak)
  );

  mmcd_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  ({push_ctl, push_idx, push_peak}),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign {q_ctl, q_idx, q_peak} = q_data;

  mmcd_emitter #(
    .INDEX_BITS (INDEX_BITS)
  ) u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid_i      (q_valid),
    .q_ctl_i        (q_ctl),
    .q_idx_i        (q_idx),
    .q_peak_i       (q_peak),
    .pop_o          (pop),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_index_o    (out_selected_index),
    .out_run_end_o  (out_run_end),
    .out_scan_end_o (out_scan_end),
    .out_peak_o     (out_peak_intensity)
  );

endmodule
`default_nettype wire

// ----- bench/minmax_column_decimator_unit_tb.sv -----
// Self-checking testbench for the min/max column decimator: point stream driver, result monitor.
`timescale 1ns / 1ps
module minmax_column_decimator_unit_tb;
  import mmcd_pkg::*;

  localparam int         IDX_W      = 24;
  localparam int         COLS_LIMIT = 4096;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic [INT_BITS-1:0] level;
    logic [IDX_W-1:0]    idx;
    logic                last;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic                run_end;
    logic                scan_end;
    logic [INT_BITS-1:0] peak;
  } selection_t;

  logic                     clk;
  logic                     rst_n              = 1'b0;
  logic                     in_valid           = 1'b0;
  logic                     in_stall;
  logic [POS_BITS-1:0]      in_point_position  = '0;
  logic [INT_BITS-1:0]      in_point_intensity = '0;
  logic [IDX_W-1:0]         in_point_index     = '0;
  logic                     in_last_point      = 1'b0;
  logic                     out_valid;
  logic                     out_stall          = 1'b0;
  logic [IDX_W-1:0]         out_selected_index;
  logic                     out_run_end;
  logic                     out_scan_end;
  logic [INT_BITS-1:0]      out_peak_intensity;
  logic                     cfg_we             = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index          = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data           = '0;

  minmax_column_decimator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_point_position  (in_point_position),
    .in_point_intensity (in_point_intensity),
    .in_point_index     (in_point_index),
    .in_last_point      (in_last_point),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_selected_index (out_selected_index),
    .out_run_end        (out_run_end),
    .out_scan_end       (out_scan_end),
    .out_peak_intensity (out_peak_intensity),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow configuration and column-run state of the block
  logic [31:0]      vmin_reg  = RESET_VIEW_MIN;
  logic [31:0]      scale_reg = RESET_SCALE;
  logic [12:0]      cols_reg  = RESET_COLUMNS;
  int               col_now   = 0;
  bit               run_open  = 1'b0;
  logic [IDX_W-1:0] first_idx = '0;
  logic [IDX_W-1:0] low_idx   = '0;
  logic [IDX_W-1:0] high_idx  = '0;
  logic [IDX_W-1:0] prev_idx  = '0;
  logic [31:0]      low_val   = '0;
  logic [31:0]      high_val  = '0;
  logic [31:0]      peak_val  = PEAK_FLOOR;
  bit               sent_any  = 1'b0;
  logic [IDX_W-1:0] sent_last = '0;

  point_t           pending_points[$];
  selection_t       awaited[$];
  logic [IDX_W-1:0] step_picks[$];

  int mismatches      = 0;
  int phase_no        = 0;
  bit sender_idling   = 1'b0;
  bit receiver_idling = 1'b0;
  bit receiver_hold   = 1'b0;

  function automatic int column_for(logic [31:0] pos);
    logic [63:0]  prod;
    logic [63:0]  q;
    int unsigned  span;
    span = (cols_reg == 0) ? 1 : ((cols_reg > COLS_LIMIT) ? COLS_LIMIT : 32'(cols_reg));
    if (pos >= vmin_reg) begin
      prod = {32'd0, pos - vmin_reg} * {32'd0, scale_reg};
      q = prod >> 16;
      if (q > 64'(2 * span)) q = 64'(2 * span);
      return int'(q);
    end
    // round toward minus infinity left of the view
    prod = {32'd0, vmin_reg - pos} * {32'd0, scale_reg};
    q = (prod + 64'hFFFF) >> 16;
    if (q > 64'(span)) q = 64'(span);
    return -int'(q);
  endfunction

  function automatic void close_run();
    logic [IDX_W-1:0] v [4];
    logic [IDX_W-1:0] t;
    int i;
    int j;
    v[0] = first_idx;
    v[1] = low_idx;
    v[2] = high_idx;
    v[3] = prev_idx;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3 - i; j++)
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
    // drop an index equal to the one sent just before it
    for (i = 0; i < 4; i++)
      if (!sent_any || sent_last != v[i]) begin
        step_picks.push_back(v[i]);
        sent_any = 1'b1;
        sent_last = v[i];
      end
  endfunction

  function automatic void decimate_point(point_t p);
    int         col;
    int         k;
    selection_t s;
    step_picks.delete();
    col = column_for(p.pos);
    if (run_open && col != col_now) close_run();
    if (!run_open || col != col_now) begin
      run_open = 1'b1;
      col_now = col;
      first_idx = p.idx;
      low_idx = p.idx;
      high_idx = p.idx;
      low_val = p.level;
      high_val = p.level;
    end else begin
      if (p.level < low_val) begin
        low_val = p.level;
        low_idx = p.idx;
      end
      if (p.level > high_val) begin
        high_val = p.level;
        high_idx = p.idx;
      end
    end
    prev_idx = p.idx;
    if (p.level > peak_val) peak_val = p.level;
    if (p.last) begin
      close_run();
      // everything deduplicated away: repeat the last index sent
      if (step_picks.size() == 0) step_picks.push_back(sent_last);
    end
    for (k = 0; k < step_picks.size(); k++) begin
      s.idx = step_picks[k];
      s.peak = peak_val;
      s.run_end = (k == step_picks.size() - 1);
      s.scan_end = p.last && (k == step_picks.size() - 1);
      awaited.push_back(s);
    end
    if (p.last) begin
      run_open = 1'b0;
      col_now = 0;
      peak_val = PEAK_FLOOR;
      sent_any = 1'b0;
      sent_last = '0;
    end
  endfunction

  // Point driver
  always @(posedge clk) begin : drive_points
    bit     taken;
    int     gap;
    point_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        p.pos = in_point_position;
        p.level = in_point_intensity;
        p.idx = in_point_index;
        p.last = in_last_point;
        decimate_point(p);
        void'(pending_points.pop_front());
      end
      if (!(in_valid && !taken)) begin
        if (gap != 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_points.size() != 0 && sender_idling &&
                     $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          p = pending_points[0];
          in_valid <= 1'b1;
          in_point_position <= p.pos;
          in_point_intensity <= p.level;
          in_point_index <= p.idx;
          in_last_point <= p.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin : watch_results
    int         gap;
    selection_t s;
    if (!rst_n) begin
      out_stall <= 1'b0;
      gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: index %h run_end %b scan_end %b peak %h",
                     out_selected_index, out_run_end, out_scan_end, out_peak_intensity);
        end else begin
          s = awaited.pop_front();
          if (s.idx !== out_selected_index || s.run_end !== out_run_end ||
              s.scan_end !== out_scan_end || s.peak !== out_peak_intensity) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: index %h/%h run_end %b/%b scan_end %b/%b peak %h/%h",
                       s.idx, out_selected_index, s.run_end, out_run_end,
                       s.scan_end, out_scan_end, s.peak, out_peak_intensity);
          end
        end
      end
      if (receiver_hold) begin
        out_stall <= 1'b1;
      end else if (gap != 0) begin
        gap--;
        out_stall <= 1'b1;
      end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off while points keep coming, so the block backs up
  initial begin
    wait (phase_no == 2);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (150) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("minmax_column_decimator_unit regression: fail");
    $finish;
  end

  task automatic write_reg(logic [1:0] which, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (which)
      CFG_VIEW_MIN: vmin_reg = value;
      CFG_SCALE:    scale_reg = value;
      CFG_COLUMNS:  cols_reg = value[12:0];
      default:      ;
    endcase
  endtask

  task automatic add_point(logic [31:0] pos, logic [31:0] level, logic [23:0] idx, bit last);
    point_t p;
    p.pos = pos;
    p.level = level;
    p.idx = idx;
    p.last = last;
    pending_points.push_back(p);
  endtask

  function automatic logic [31:0] pick_level();
    unique case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Ascending scans with random content; a share of noise points breaks them
  task automatic add_scans(int count, logic [31:0] base, int unsigned step, int noise);
    int          left;
    int          run_len;
    int          k;
    logic [32:0] pos;
    logic [23:0] idx;
    point_t      p;
    left = count;
    idx = 24'($urandom);
    while (left > 0) begin
      run_len = $urandom_range(1, 24);
      if (run_len > left) run_len = left;
      pos = {1'b0, base};
      for (k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 99) < noise) begin
          p.pos = $urandom;
          p.level = $urandom;
          p.idx = 24'($urandom);
          p.last = ($urandom_range(0, 7) == 0);
        end else begin
          pos = pos + $urandom_range(0, step);
          if (pos[32]) pos = 33'h0_FFFF_FFFF;
          idx = idx + 24'($urandom_range(0, 3));
          p.pos = pos[31:0];
          p.level = pick_level();
          p.idx = idx;
          p.last = 1'b0;
        end
        if (k == run_len - 1) p.last = 1'b1;
        pending_points.push_back(p);
      end
      left -= run_len;
    end
  endtask

  // Wait for the sender to empty and every awaited result to arrive
  task automatic settle();
    while (pending_points.size() != 0 || in_valid) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] vm, logic [31:0] sc, logic [31:0] cols, int count,
                           logic [31:0] base, int unsigned step, int noise);
    write_reg(CFG_VIEW_MIN, vm);
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_COLUMNS, cols);
    @(negedge clk);
    add_scans(count, base, step, noise);
    settle();
  endtask

  initial begin
    logic [31:0] rnd_vm;
    logic [31:0] rnd_sc;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed points: one column per position code, 16 columns
    phase_no = 1;
    sender_idling = 1'b1;
    receiver_idling = 1'b1;
    write_reg(CFG_VIEW_MIN, 32'd1000);
    write_reg(CFG_SCALE, 32'd65536);
    write_reg(CFG_COLUMNS, 32'd16);
    @(negedge clk);
    add_point(32'd0, 32'd0, 24'd0, 1'b0);
    add_point(32'd990, 32'hFFFF_FFFF, 24'd1, 1'b0);
    add_point(32'd1000, 32'd5, 24'd2, 1'b0);
    add_point(32'd1000, 32'd3, 24'd3, 1'b0);
    add_point(32'd1000, 32'd9, 24'd4, 1'b0);
    add_point(32'd1000, 32'd3, 24'd5, 1'b0);
    add_point(32'd1001, 32'd7, 24'd6, 1'b0);
    add_point(32'd2000, 32'd1, 24'd7, 1'b0);
    add_point(32'hFFFF_FFFF, 32'd0, 24'hFF_FFFF, 1'b1);
    // repeated index leaves the final run with nothing new to send
    add_point(32'd1005, 32'd2, 24'd10, 1'b0);
    add_point(32'd1006, 32'd2, 24'd10, 1'b0);
    add_point(32'd1006, 32'd2, 24'd10, 1'b1);
    // single point scan at zero intensity: peak stays at its floor
    add_point(32'd1000, 32'd0, 24'd0, 1'b1);
    // closing a four-index run on the last point gives five results
    add_point(32'd1010, 32'd5, 24'd20, 1'b0);
    add_point(32'd1010, 32'd1, 24'd21, 1'b0);
    add_point(32'd1010, 32'd9, 24'd22, 1'b0);
    add_point(32'd1010, 32'd4, 24'd23, 1'b0);
    add_point(32'd1011, 32'd6, 24'd24, 1'b1);
    // indices out of order within a run, then a step back in position
    add_point(32'd1020, 32'd8, 24'd40, 1'b0);
    add_point(32'd1020, 32'd2, 24'd35, 1'b0);
    add_point(32'd1020, 32'd9, 24'd30, 1'b0);
    add_point(32'd1019, 32'd4, 24'd45, 1'b1);
    settle();

    // coarse scale, one column for the whole view: receiver holds off here
    phase_no = 2;
    run_phase(32'h8000_0000, 32'd1, 32'd0, 80, 32'h7FFD_B610, 20000, 10);

    phase_no = 3;
    rnd_vm = $urandom_range(1000, 1 << 20);
    run_phase(rnd_vm, 32'd8192, 32'd4096, 80, rnd_vm - 100, 6, 5);

    // top of the code range with the steepest scale, spare index ignored
    phase_no = 4;
    write_reg(CFG_SPARE, $urandom);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8191, 40, 32'hFFFF_FFCD, 4, 10);

    // zero scale puts every point in one column
    phase_no = 5;
    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    run_phase(32'd0, 32'd0, 32'd1, 40, $urandom, 50000, 10);

    phase_no = 6;
    sender_idling = 1'b1;
    receiver_idling = 1'b1;
    rnd_vm = $urandom;
    rnd_sc = $urandom_range(256, 262144);
    run_phase(rnd_vm, rnd_sc, $urandom_range(1, 4096), 80,
              (rnd_vm > 32'd5000) ? rnd_vm - 32'd5000 : 32'd0, 131072 / rnd_sc + 1, 25);

    // back to reset settings, no idling to the end
    phase_no = 7;
    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    run_phase(RESET_VIEW_MIN, RESET_SCALE, 32'(RESET_COLUMNS), 70,
              $urandom_range(0, 2000), 2, 5);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0)
      $display("minmax_column_decimator_unit regression: pass");
    else
      $display("minmax_column_decimator_unit regression: fail");
    $finish;
  end

endmodule
